// File: hdl/serial_setpoint_command_parser_unit_defines.svh
// Assertion helpers for the setpoint parser checkers.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef SERIAL_SETPOINT_COMMAND_PARSER_UNIT_DEFINES_SVH
`define SERIAL_SETPOINT_COMMAND_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication
`define SSP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/ssp_pkg.sv
package ssp_pkg;

  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_CURRENT = 3'd1,
    CMD_VOLTS   = 3'd2,
    CMD_ON      = 3'd3,
    CMD_OFF     = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    PH_SKIP   = 2'd0,
    PH_DIGITS = 2'd1,
    PH_DONE   = 2'd2
  } phase_t;

  typedef struct packed {
    cmd_t               command_code;
    logic               volts_write;
    logic signed [15:0] volts_value;
    logic               current_write;
    logic signed [15:0] current_value;
    logic               output_enabled;
  } result_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_UC_C  = 8'h43;
  localparam logic [7:0] CH_UC_V  = 8'h56;
  localparam logic [7:0] CH_UC_N  = 8'h4E;
  localparam logic [7:0] CH_UC_F  = 8'h46;
  localparam logic [7:0] CH_LC_C  = 8'h63;
  localparam logic [7:0] CH_LC_V  = 8'h76;
  localparam logic [7:0] CH_LC_N  = 8'h6E;
  localparam logic [7:0] CH_LC_F  = 8'h66;

endpackage

// File: hdl/ssp_if.sv
interface ssp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface ssp_result_if;
  logic               valid;
  logic               ready;
  logic [2:0]         command_code;
  logic               volts_write;
  logic signed [15:0] volts_value;
  logic               current_write;
  logic signed [15:0] current_value;
  logic               output_enabled;

  modport source (output valid, output command_code, output volts_write,
                  output volts_value, output current_write, output current_value,
                  output output_enabled, input ready);
  modport sink (input valid, input command_code, input volts_write,
                input volts_value, input current_write, input current_value,
                input output_enabled, output ready);
endinterface

// File: hdl/ssp_in_stage.sv
// Input register: holds one received byte until the parser takes it.
module ssp_in_stage (
  input  logic        clk,
  input  logic        rst,
  ssp_byte_if.sink    rx,
  input  logic        take,
  output logic        held_valid,
  output logic [7:0]  held_byte
);

  assign rx.ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (rx.ready) begin
      held_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      held_byte <= rx.rx_byte;
    end
  end

endmodule

// File: hdl/ssp_line_parser.sv
// Line state, atoi-style number scan and command decode.
// State moves on step; a carriage return yields the result combinationally.
module ssp_line_parser #(
  parameter int LINE_MAX = 80
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       ch,
  output logic             is_cr,
  output ssp_pkg::result_t result
);

  localparam int LEN_W = $clog2(LINE_MAX);
  localparam logic [LEN_W-1:0] LEN_LAST = LEN_W'(LINE_MAX - 1);

  logic [LEN_W-1:0]  line_length, line_length_next;
  logic              text_ended, text_ended_next;
  logic [7:0]        command_char, command_char_next;
  logic              have_command_char, have_command_char_next;
  ssp_pkg::phase_t   number_phase, number_phase_next;
  logic              number_negative, number_negative_next;
  logic [15:0]       number_accumulator, number_accumulator_next;
  logic [15:0]       volts_setpoint, volts_setpoint_next;
  logic [15:0]       current_setpoint, current_setpoint_next;
  logic              output_on, output_on_next;

  logic              is_digit, is_space, is_sign;
  logic [15:0]       value;
  logic [15:0]       acc_times_ten;

  assign is_cr    = (ch == ssp_pkg::CH_CR);
  assign is_digit = (ch >= ssp_pkg::CH_ZERO) && (ch <= ssp_pkg::CH_NINE);
  assign is_space = ((ch >= ssp_pkg::CH_TAB) && (ch <= ssp_pkg::CH_CR)) ||
                    (ch == ssp_pkg::CH_SPACE);
  assign is_sign  = (ch == ssp_pkg::CH_PLUS) || (ch == ssp_pkg::CH_MINUS);
  // x*10 = x*8 + x*2, wraps mod 2^16
  assign acc_times_ten = {number_accumulator[12:0], 3'b000} +
                         {number_accumulator[14:0], 1'b0};
  assign value = number_negative ? (16'd0 - number_accumulator) : number_accumulator;

  always_comb begin
    line_length_next        = line_length;
    text_ended_next         = text_ended;
    command_char_next       = command_char;
    have_command_char_next  = have_command_char;
    number_phase_next       = number_phase;
    number_negative_next    = number_negative;
    number_accumulator_next = number_accumulator;
    volts_setpoint_next     = volts_setpoint;
    current_setpoint_next   = current_setpoint;
    output_on_next          = output_on;

    result = '{command_code:   ssp_pkg::CMD_NONE,
               volts_write:    1'b0,
               volts_value:    16'sd0,
               current_write:  1'b0,
               current_value:  16'sd0,
               output_enabled: output_on};

    if (!is_cr) begin
      if (line_length != LEN_LAST) begin
        line_length_next = line_length + 1'b1;
        if (!text_ended) begin
          if (ch == ssp_pkg::CH_NUL) begin
            text_ended_next = 1'b1;
          end else if (ch == ssp_pkg::CH_COLON) begin
            command_char_next       = 8'd0;
            have_command_char_next  = 1'b0;
            number_phase_next       = ssp_pkg::PH_SKIP;
            number_negative_next    = 1'b0;
            number_accumulator_next = 16'd0;
          end else if (!have_command_char) begin
            command_char_next      = ch;
            have_command_char_next = 1'b1;
          end else if (number_phase == ssp_pkg::PH_SKIP && is_space) begin
            // leading whitespace: nothing to do
          end else if (number_phase == ssp_pkg::PH_SKIP && is_sign) begin
            number_negative_next = (ch == ssp_pkg::CH_MINUS);
            number_phase_next    = ssp_pkg::PH_DIGITS;
          end else if (number_phase != ssp_pkg::PH_DONE && is_digit) begin
            number_accumulator_next = acc_times_ten + {12'd0, ch[3:0]};
            number_phase_next       = ssp_pkg::PH_DIGITS;
          end else begin
            number_phase_next = ssp_pkg::PH_DONE;
          end
        end
      end
    end else begin
      if (have_command_char) begin
        case (command_char)
          ssp_pkg::CH_UC_C, ssp_pkg::CH_LC_C: begin
            result.command_code   = ssp_pkg::CMD_CURRENT;
            current_setpoint_next = value;
            if (output_on) begin
              result.current_write = 1'b1;
              result.current_value = value;
            end
          end
          ssp_pkg::CH_UC_V, ssp_pkg::CH_LC_V: begin
            result.command_code = ssp_pkg::CMD_VOLTS;
            volts_setpoint_next = value;
            if (output_on) begin
              result.volts_write = 1'b1;
              result.volts_value = value;
            end
          end
          ssp_pkg::CH_UC_N, ssp_pkg::CH_LC_N: begin
            result.command_code  = ssp_pkg::CMD_ON;
            output_on_next       = 1'b1;
            result.volts_write   = 1'b1;
            result.volts_value   = volts_setpoint;
            result.current_write = 1'b1;
            result.current_value = current_setpoint;
          end
          ssp_pkg::CH_UC_F, ssp_pkg::CH_LC_F: begin
            result.command_code  = ssp_pkg::CMD_OFF;
            output_on_next       = 1'b0;
            result.volts_write   = 1'b1;
            result.current_write = 1'b1;
          end
          default: begin
          end
        endcase
      end
      result.output_enabled   = output_on_next;
      line_length_next        = '0;
      text_ended_next         = 1'b0;
      command_char_next       = 8'd0;
      have_command_char_next  = 1'b0;
      number_phase_next       = ssp_pkg::PH_SKIP;
      number_negative_next    = 1'b0;
      number_accumulator_next = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length        <= '0;
      text_ended         <= 1'b0;
      command_char       <= 8'd0;
      have_command_char  <= 1'b0;
      number_phase       <= ssp_pkg::PH_SKIP;
      number_negative    <= 1'b0;
      number_accumulator <= 16'd0;
      volts_setpoint     <= 16'd0;
      current_setpoint   <= 16'd0;
      output_on          <= 1'b0;
    end else if (step) begin
      line_length        <= line_length_next;
      text_ended         <= text_ended_next;
      command_char       <= command_char_next;
      have_command_char  <= have_command_char_next;
      number_phase       <= number_phase_next;
      number_negative    <= number_negative_next;
      number_accumulator <= number_accumulator_next;
      volts_setpoint     <= volts_setpoint_next;
      current_setpoint   <= current_setpoint_next;
      output_on          <= output_on_next;
    end
  end

endmodule

// File: hdl/ssp_out_stage.sv
// Result register toward the sink.
module ssp_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  ssp_pkg::result_t push_result,
  output logic             free,
  ssp_result_if.source     res
);

  logic             valid;
  ssp_pkg::result_t data;

  assign free = !valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (push) begin
      valid <= 1'b1;
    end else if (res.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data <= push_result;
    end
  end

  assign res.valid          = valid;
  assign res.command_code   = data.command_code;
  assign res.volts_write    = data.volts_write;
  assign res.volts_value    = data.volts_value;
  assign res.current_write  = data.current_write;
  assign res.current_value  = data.current_value;
  assign res.output_enabled = data.output_enabled;

endmodule

// File: hdl/serial_setpoint_command_parser_unit.sv
// Serial setpoint command parser. Feed received characters one per transaction
// on rx; every carriage return produces exactly one result transaction on res,
// all other characters produce none. Only the text after the last colon of a
// line counts, and a zero byte ends that text. Its first character selects the
// command (case-insensitive): C sets the current setpoint, V the voltage
// setpoint, N turns the output on, F turns it off, anything else is no command
// (code 0, nothing written). C and V take an atoi-style number from the rest of
// the text (leading whitespace, optional sign, decimal digits, 16-bit wrap);
// the setpoint is always stored but the DAC is only written while the output is
// on. N writes both DACs with the stored setpoints, F writes both with zero.
// Characters beyond LINE_MAX-1 in a line are dropped. Throughput is one
// character per clock while res does not stall: the byte sits in an input
// register, the line state is updated by a single short pass of logic, and a
// carriage-return result lands in a result register, so a result passes
// through the input register and then the result register before it is valid
// on res. A stall on res blocks only when a carriage return waits for the
// full result register; the input stalls behind it until the result is
// taken, and all other characters keep flowing.
module serial_setpoint_command_parser_unit #(
  parameter int LINE_MAX = 80
) (
  input  logic         clk,
  input  logic         rst,
  ssp_byte_if.sink     rx,
  ssp_result_if.source res
);

  logic             held_valid;
  logic [7:0]       held_byte;
  logic             is_cr;
  logic             out_free;
  logic             step;
  ssp_pkg::result_t line_result;

  // A held byte moves on unless it is a carriage return and the result
  // register cannot take its transaction this cycle.
  assign step = held_valid && (!is_cr || out_free);

  ssp_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx),
    .take       (step),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  ssp_line_parser #(
    .LINE_MAX (LINE_MAX)
  ) u_parser (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .ch     (held_byte),
    .is_cr  (is_cr),
    .result (line_result)
  );

  ssp_out_stage u_out (
    .clk         (clk),
    .rst         (rst),
    .push        (step && is_cr),
    .push_result (line_result),
    .free        (out_free),
    .res         (res)
  );

endmodule

// File: hdl/ssp_port_checker.sv
`include "serial_setpoint_command_parser_unit_defines.svh"

module ssp_port_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  command_code,
  input logic        volts_write,
  input logic [15:0] volts_value,
  input logic        current_write,
  input logic [15:0] current_value,
  input logic        output_enabled
);

  `SSP_ASSERT_NEXT(a_res_hold, out_valid && !out_ready, out_valid && $stable(command_code) && $stable(volts_value) && $stable(current_value) && $stable(output_enabled), "result changed while stalled")
  `SSP_ASSERT_NOW(a_off_zero, out_valid && command_code == ssp_pkg::CMD_OFF, !output_enabled && volts_write && current_write && volts_value == 16'd0 && current_value == 16'd0, "off command must zero both DACs")
  `SSP_ASSERT_NOW(a_on_writes, out_valid && command_code == ssp_pkg::CMD_ON, output_enabled && volts_write && current_write, "on command must write both DACs")
  `SSP_ASSERT_NOW(a_set_gated, out_valid && (command_code == ssp_pkg::CMD_CURRENT || command_code == ssp_pkg::CMD_VOLTS || command_code == ssp_pkg::CMD_NONE), (!volts_write || output_enabled) && (!current_write || output_enabled) && !(volts_write && current_write), "DAC write without enabled output")

endmodule

bind serial_setpoint_command_parser_unit ssp_port_checker u_ssp_port_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (res.valid),
  .out_ready      (res.ready),
  .command_code   (res.command_code),
  .volts_write    (res.volts_write),
  .volts_value    (res.volts_value),
  .current_write  (res.current_write),
  .current_value  (res.current_value),
  .output_enabled (res.output_enabled)
);
